FILE: hdl/ttse_pkg.sv
// Shared types, codes and constants for the tick timer and switch event block.
`timescale 1ns / 1ps

package ttse_pkg;

  // Defaults for the channel counts
  localparam int LED_CHANNELS_DEF = 4;
  localparam int USER_TIMERS_DEF  = 4;

  // Field widths
  localparam int PERIOD_W  = 7;
  localparam int MS_W      = 16;
  localparam int PINS_W    = 4;
  localparam int REM_W     = 23;
  localparam int SEC_W     = 31;
  localparam int ACC_W     = 10;
  localparam int LED_CNT_W = 8;
  localparam int USR_CNT_W = 16;
  localparam int FLS_CNT_W = 8;
  localparam int NUM_W     = MS_W + 1;
  localparam int STEP_W    = 5;

  // Packed stream widths
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 72;

  // Time constants
  localparam int unsigned MS_PER_SECOND    = 1000;
  localparam int unsigned FLUSH_TIMEOUT_MS = 100;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd10;
  localparam logic [LED_CNT_W-1:0] LED_CNT_MAX = 8'hff;

  // Request function codes
  typedef enum logic [2:0] {
    FN_TICK        = 3'd0,
    FN_SET_TIMER   = 3'd1,
    FN_READ_TIMER  = 3'd2,
    FN_FLASH_LED   = 3'd3,
    FN_LED_ON      = 3'd4,
    FN_LED_OFF     = 3'd5,
    FN_ARM_FLUSH   = 3'd6,
    FN_CLEAR_FLUSH = 3'd7
  } func_t;

  // Switch event codes
  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_OFF  = 2'd1,
    EV_DOWN = 2'd2,
    EV_UP   = 2'd3
  } sw_event_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_t;

  // Map an active-high switch position to its event code
  function automatic sw_event_t sw_event(input logic [1:0] pos);
    sw_event_t ev;
    case (pos)
      2'd0:    ev = EV_OFF;
      2'd1:    ev = EV_DOWN;
      2'd2:    ev = EV_UP;
      default: ev = EV_NONE;
    endcase
    return ev;
  endfunction

endpackage

FILE: hdl/tick_timers_and_switch_events.sv
// Top level of the poll-tick timer, LED flash and switch event block.
//
//  channel  dir  fields (tuser / tdata, lowest bit first)
//  s_*      in   tuser: func[2:0]; tdata: channel[1:0], duration_ms[17:2],
//                switch_pins[21:18], zero fill [23:22]
//  m_*      out  tdata: timer_expired[3:0], flush_due[4], switch1_event[6:5],
//                switch2_event[8:7], led_lit[12:9], remaining_ms[35:13],
//                seconds[66:36], zero fill [71:67]
//  cfg_*    in   data: poll_period_ms[6:0]
//
// Tick, LED on/off and clear-flush requests, and requests on a bad channel, are
// answered from idle. Set timer, flash LED and arm flush run 17 steps of the shared
// add/subtract unit, a restoring divide by the poll period; read timer runs 7
// shift-add steps of the same unit. A finished result waits in the output register;
// the block takes no new request until that register can be loaded. rst is
// synchronous and clears all timers, LEDs, switch history and the seconds clock.
`timescale 1ns / 1ps

module tick_timers_and_switch_events
  import ttse_pkg::*;
#(
  parameter int LED_CHANNELS = LED_CHANNELS_DEF,
  parameter int USER_TIMERS  = USER_TIMERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // channel, duration_ms, switch_pins
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // func
  input  logic [S_TUSER_W-1:0]  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // timer_expired, flush_due, switch1_event, switch2_event, led_lit,
  // remaining_ms, seconds
  output logic [M_TDATA_W-1:0]  m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  // poll_period_ms
  input  logic [PERIOD_W-1:0]   cfg_data
);

  localparam int LED_W = (LED_CHANNELS > 4) ? LED_CHANNELS : 4;
  localparam int USR_W = (USER_TIMERS > 4) ? USER_TIMERS : 4;

  // Configuration
  logic [PERIOD_W-1:0] period;
  logic [PERIOD_W-1:0] p;

  // Architectural state
  logic [LED_CNT_W-1:0] led_cnt      [LED_CHANNELS];
  logic [LED_CNT_W-1:0] led_cnt_next [LED_CHANNELS];
  logic [USR_CNT_W-1:0] user_cnt      [USER_TIMERS];
  logic [USR_CNT_W-1:0] user_cnt_next [USER_TIMERS];
  logic [FLS_CNT_W-1:0] flush_cnt, flush_cnt_next;
  logic [LED_CHANNELS-1:0] led_on, led_on_next;
  logic [PINS_W-1:0]    last_sw, last_sw_next;
  logic [ACC_W-1:0]     ms_acc, ms_acc_next;
  logic [SEC_W-1:0]     sec_cnt, sec_cnt_next;

  // Sequencer and shared unit operands
  state_t               state, state_next;
  func_t                op_func, op_func_next;
  logic [1:0]           op_ch, op_ch_next;
  logic [STEP_W-1:0]    step, step_next;
  logic [NUM_W-1:0]     dq, dq_next;
  logic [PERIOD_W-1:0]  drem, drem_next;
  logic [REM_W-1:0]     acc, acc_next;
  logic [REM_W-1:0]     mcand, mcand_next;
  logic [PERIOD_W-1:0]  mplier, mplier_next;

  // Output register
  logic                 out_valid_next;
  logic [3:0]           o_expired, o_expired_next;
  logic                 o_flush, o_flush_next;
  sw_event_t            o_ev1, o_ev1_next;
  sw_event_t            o_ev2, o_ev2_next;
  logic [3:0]           o_led, o_led_next;
  logic [REM_W-1:0]     o_rem, o_rem_next;
  logic [SEC_W-1:0]     o_sec, o_sec_next;

  // Shared add/subtract unit
  logic [REM_W-1:0]     alu_a, alu_b, alu_sum;
  logic                 alu_sub;

  // Request fields
  func_t                in_func;
  logic [1:0]           in_ch;
  logic [MS_W-1:0]      in_ms;
  logic [PINS_W-1:0]    in_pins;
  logic                 accept;
  logic                 out_free;

  // Tick helpers
  logic [ACC_W:0]       ms_sum;
  logic [PINS_W-1:0]    sw_now, sw_diff;
  logic [USR_W-1:0]     expired_all;
  logic [LED_W-1:0]     led_wide;
  logic [7:0]           div_r2;
  logic                 div_bit;
  logic [USR_CNT_W-1:0] rd_cnt;
  logic                 ch_led_ok, ch_user_ok;

  assign p         = (period == '0) ? PERIOD_W'(1) : period;
  assign in_func   = func_t'(s_tuser);
  assign in_ch     = s_tdata[1:0];
  assign in_ms     = s_tdata[17:2];
  assign in_pins   = s_tdata[21:18];
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign accept    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign m_tdata = {5'd0, o_sec, o_rem, o_led, o_ev2, o_ev1, o_flush, o_expired};

  // Shared unit: one 23-bit adder that also subtracts
  assign alu_sum = alu_a + (alu_b ^ {REM_W{alu_sub}}) + REM_W'(alu_sub);

  // Divide step operand: partial remainder with next dividend bit
  assign div_r2  = {drem, dq[NUM_W-1]};
  assign div_bit = !alu_sum[REM_W-1];

  // Drive the shared unit from the active step
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state)
      ST_DIV: begin
        alu_a   = REM_W'(div_r2);
        alu_b   = REM_W'(p);
        alu_sub = 1'b1;
      end
      ST_MUL: begin
        alu_a = acc;
        alu_b = mcand;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
  end

  // Select the addressed user timer for a read and check channel range
  always_comb begin
    rd_cnt = '0;
    for (int i = 0; i < USER_TIMERS; i++) begin
      if (32'(in_ch) == i) rd_cnt = user_cnt[i];
    end
  end

  assign ch_user_ok = 32'(in_ch) < USER_TIMERS;
  assign ch_led_ok  = 32'(in_ch) < LED_CHANNELS;
  assign ms_sum     = (ACC_W+1)'(ms_acc) + (ACC_W+1)'(p);
  assign sw_now     = ~in_pins;
  assign sw_diff    = sw_now ^ last_sw;

  // Sequencer: next state, state updates and result load
  always_comb begin
    state_next     = state;
    op_func_next   = op_func;
    op_ch_next     = op_ch;
    step_next      = step;
    dq_next        = dq;
    drem_next      = drem;
    acc_next       = acc;
    mcand_next     = mcand;
    mplier_next    = mplier;
    led_cnt_next   = led_cnt;
    user_cnt_next  = user_cnt;
    flush_cnt_next = flush_cnt;
    led_on_next    = led_on;
    last_sw_next   = last_sw;
    ms_acc_next    = ms_acc;
    sec_cnt_next   = sec_cnt;
    expired_all    = '0;
    led_wide       = '0;

    out_valid_next = m_tvalid && !m_tready;
    o_expired_next = o_expired;
    o_flush_next   = o_flush;
    o_ev1_next     = o_ev1;
    o_ev2_next     = o_ev2;
    o_led_next     = o_led;
    o_rem_next     = o_rem;
    o_sec_next     = o_sec;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          op_func_next   = in_func;
          op_ch_next     = in_ch;
          out_valid_next = 1'b1;
          o_expired_next = '0;
          o_flush_next   = 1'b0;
          o_ev1_next     = EV_NONE;
          o_ev2_next     = EV_NONE;
          o_rem_next     = '0;
          case (in_func)
            FN_TICK: begin
              // advance seconds clock
              if (ms_sum >= (ACC_W+1)'(MS_PER_SECOND)) begin
                ms_acc_next  = ACC_W'(ms_sum - (ACC_W+1)'(MS_PER_SECOND));
                sec_cnt_next = sec_cnt + SEC_W'(1);
              end else begin
                ms_acc_next = ACC_W'(ms_sum);
              end
              // count down LED flash timers
              for (int i = 0; i < LED_CHANNELS; i++) begin
                if (led_cnt[i] != '0) begin
                  led_cnt_next[i] = led_cnt[i] - LED_CNT_W'(1);
                  if (led_cnt[i] == LED_CNT_W'(1)) led_on_next[i] = 1'b0;
                end
              end
              // count down user timers
              for (int i = 0; i < USER_TIMERS; i++) begin
                if (user_cnt[i] != '0) begin
                  user_cnt_next[i] = user_cnt[i] - USR_CNT_W'(1);
                  if (user_cnt[i] == USR_CNT_W'(1)) expired_all[i] = 1'b1;
                end
              end
              o_expired_next = expired_all[3:0];
              // count down flush timer
              if (flush_cnt != '0) begin
                flush_cnt_next = flush_cnt - FLS_CNT_W'(1);
                o_flush_next   = (flush_cnt == FLS_CNT_W'(1));
              end
              // decode switch changes
              last_sw_next = sw_now;
              if (sw_diff[3:2] != 2'b00) o_ev1_next = sw_event(sw_now[3:2]);
              if (sw_diff[1:0] != 2'b00) o_ev2_next = sw_event(sw_now[1:0]);
            end
            FN_SET_TIMER: begin
              if (ch_user_ok) begin
                dq_next        = NUM_W'(in_ms) + NUM_W'(p - PERIOD_W'(1));
                drem_next      = '0;
                step_next      = STEP_W'(NUM_W);
                state_next     = ST_DIV;
                out_valid_next = m_tvalid && !m_tready;
              end
            end
            FN_READ_TIMER: begin
              if (ch_user_ok) begin
                acc_next       = '0;
                mcand_next     = REM_W'(rd_cnt);
                mplier_next    = p;
                step_next      = STEP_W'(PERIOD_W);
                state_next     = ST_MUL;
                out_valid_next = m_tvalid && !m_tready;
              end
            end
            FN_FLASH_LED: begin
              if (ch_led_ok) begin
                dq_next        = NUM_W'(in_ms);
                drem_next      = '0;
                step_next      = STEP_W'(NUM_W);
                state_next     = ST_DIV;
                out_valid_next = m_tvalid && !m_tready;
              end
            end
            FN_LED_ON: begin
              for (int i = 0; i < LED_CHANNELS; i++) begin
                if (32'(in_ch) == i) led_on_next[i] = 1'b1;
              end
            end
            FN_LED_OFF: begin
              for (int i = 0; i < LED_CHANNELS; i++) begin
                if (32'(in_ch) == i) led_on_next[i] = 1'b0;
              end
            end
            FN_ARM_FLUSH: begin
              dq_next        = NUM_W'(FLUSH_TIMEOUT_MS) + NUM_W'(p - PERIOD_W'(1));
              drem_next      = '0;
              step_next      = STEP_W'(NUM_W);
              state_next     = ST_DIV;
              out_valid_next = m_tvalid && !m_tready;
            end
            FN_CLEAR_FLUSH: begin
              flush_cnt_next = '0;
            end
            default: begin
              flush_cnt_next = '0;
            end
          endcase
        end
      end

      ST_DIV: begin
        // one restoring divide step: keep difference when no borrow
        drem_next = div_bit ? alu_sum[PERIOD_W-1:0] : div_r2[PERIOD_W-1:0];
        dq_next   = {dq[NUM_W-2:0], div_bit};
        step_next = step - STEP_W'(1);
        if (step == STEP_W'(1)) state_next = ST_DONE;
      end

      ST_MUL: begin
        // one shift-add multiply step over the period bits
        if (mplier[0]) acc_next = alu_sum;
        mcand_next  = {mcand[REM_W-2:0], 1'b0};
        mplier_next = {1'b0, mplier[PERIOD_W-1:1]};
        step_next   = step - STEP_W'(1);
        if (step == STEP_W'(1)) state_next = ST_DONE;
      end

      ST_DONE: begin
        // commit the quotient or product once the output register is free
        if (out_free) begin
          out_valid_next = 1'b1;
          o_expired_next = '0;
          o_flush_next   = 1'b0;
          o_ev1_next     = EV_NONE;
          o_ev2_next     = EV_NONE;
          o_rem_next     = '0;
          state_next     = ST_IDLE;
          case (op_func)
            FN_SET_TIMER: begin
              for (int i = 0; i < USER_TIMERS; i++) begin
                if (32'(op_ch) == i) user_cnt_next[i] = dq[USR_CNT_W-1:0];
              end
            end
            FN_FLASH_LED: begin
              for (int i = 0; i < LED_CHANNELS; i++) begin
                if (32'(op_ch) == i) begin
                  led_cnt_next[i] = (dq > NUM_W'(LED_CNT_MAX)) ? LED_CNT_MAX
                                                               : dq[LED_CNT_W-1:0];
                  led_on_next[i]  = 1'b1;
                end
              end
            end
            FN_ARM_FLUSH: begin
              flush_cnt_next = dq[FLS_CNT_W-1:0];
            end
            FN_READ_TIMER: begin
              o_rem_next = acc;
            end
            default: begin
              o_rem_next = '0;
            end
          endcase
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // LED and seconds fields always show the state after the request
    led_wide   = LED_W'(led_on_next);
    o_led_next = (state_next == ST_IDLE && (accept || state == ST_DONE)) ?
                 led_wide[3:0] : o_led;
    o_sec_next = (state_next == ST_IDLE && (accept || state == ST_DONE)) ?
                 sec_cnt_next : o_sec;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      period    <= PERIOD_RESET;
      flush_cnt <= '0;
      led_on    <= '0;
      last_sw   <= '0;
      ms_acc    <= '0;
      sec_cnt   <= '0;
      for (int i = 0; i < LED_CHANNELS; i++) led_cnt[i] <= '0;
      for (int i = 0; i < USER_TIMERS; i++) user_cnt[i] <= '0;
    end else begin
      state     <= state_next;
      m_tvalid  <= out_valid_next;
      flush_cnt <= flush_cnt_next;
      led_on    <= led_on_next;
      last_sw   <= last_sw_next;
      ms_acc    <= ms_acc_next;
      sec_cnt   <= sec_cnt_next;
      led_cnt   <= led_cnt_next;
      user_cnt  <= user_cnt_next;
      if (cfg_valid && cfg_ready) period <= cfg_data;
    end
  end

  // Operand and result payload registers
  always_ff @(posedge clk) begin
    op_func   <= op_func_next;
    op_ch     <= op_ch_next;
    step      <= step_next;
    dq        <= dq_next;
    drem      <= drem_next;
    acc       <= acc_next;
    mcand     <= mcand_next;
    mplier    <= mplier_next;
    o_expired <= o_expired_next;
    o_flush   <= o_flush_next;
    o_ev1     <= o_ev1_next;
    o_ev2     <= o_ev2_next;
    o_led     <= o_led_next;
    o_rem     <= o_rem_next;
    o_sec     <= o_sec_next;
  end

endmodule

FILE: hdl/ttse_check.sv
// Port-level checker for the tick timer and switch event block, with its bind.
`timescale 1ns / 1ps

module ttse_check
  import ttse_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TUSER_W-1:0] s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata
);

  // Reset leaves no result pending and the input open
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("result pending or input closed after reset");

  // Never take a request while a stalled result blocks the output register
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid && !m_tready))
    else $error("request taken while output register is blocked");

  // A tick request produces its result in the next cycle
  a_tick_latency: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == FN_TICK) |=> m_tvalid)
    else $error("tick result not presented in the next cycle");

  // Hold a stalled result unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or dropped");

endmodule

bind tick_timers_and_switch_events ttse_check u_ttse_check (.*);
